### rtl/joystick_nav_event_qualifier_top_defines.svh
// assertion macros used by jnq_core
`ifndef JOYSTICK_NAV_EVENT_QUALIFIER_TOP_DEFINES_SVH
`define JOYSTICK_NAV_EVENT_QUALIFIER_TOP_DEFINES_SVH

// same-cycle implication
`define JNQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JNQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/jnq_pkg.sv
package jnq_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int TIME_BITS       = 32;
  localparam int HOLD_BITS       = 16;
  localparam int EVENT_BITS      = 3;
  localparam int APB_DATA_BITS   = 32;
  localparam int PADDR_BITS      = 4;

  localparam int CENTER_X_RESET  = 1955;
  localparam int CENTER_Y_RESET  = 1880;
  localparam int DEADZONE_RESET  = 400;
  localparam int LONG_PRESS_RESET = 600;

  typedef enum logic [EVENT_BITS-1:0] {
    EV_NONE  = 3'd0,
    EV_UP    = 3'd1,
    EV_DOWN  = 3'd2,
    EV_LEFT  = 3'd3,
    EV_RIGHT = 3'd4,
    EV_OK    = 3'd5,
    EV_BACK  = 3'd6,
    EV_SHOT  = 3'd7
  } jnq_event_t;

  typedef enum logic [1:0] {
    REG_CENTER_X   = 2'd0,
    REG_CENTER_Y   = 2'd1,
    REG_DEADZONE   = 2'd2,
    REG_LONG_PRESS = 2'd3
  } jnq_reg_idx_t;

  typedef struct packed {
    logic       off;
    jnq_event_t dir;
  } jnq_deflect_t;

endpackage

### rtl/jnq_if.sv
interface jnq_in_if
  import jnq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_x;
  logic [SAMPLE_BITS-1:0] sample_y;
  logic                   switch_pressed;
  logic [TIME_BITS-1:0]   now_ms;

  modport source (output valid, sample_x, sample_y, switch_pressed, now_ms, input ready);
  modport sink (input valid, sample_x, sample_y, switch_pressed, now_ms, output ready);
endinterface

interface jnq_out_if
  import jnq_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [EVENT_BITS-1:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink (input valid, event_code, output ready);
endinterface

### rtl/jnq_cfg_regs.sv
module jnq_cfg_regs
  import jnq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_BITS-1:0]    paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [SAMPLE_BITS-1:0]   center_x,
  output logic [SAMPLE_BITS-1:0]   center_y,
  output logic [SAMPLE_BITS-1:0]   deadzone,
  output logic [HOLD_BITS-1:0]     long_press_ms
);

  jnq_reg_idx_t reg_idx;
  logic         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = jnq_reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= SAMPLE_BITS'(CENTER_X_RESET);
      center_y      <= SAMPLE_BITS'(CENTER_Y_RESET);
      deadzone      <= SAMPLE_BITS'(DEADZONE_RESET);
      long_press_ms <= HOLD_BITS'(LONG_PRESS_RESET);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CENTER_X:   center_x      <= pwdata[SAMPLE_BITS-1:0];
        REG_CENTER_Y:   center_y      <= pwdata[SAMPLE_BITS-1:0];
        REG_DEADZONE:   deadzone      <= pwdata[SAMPLE_BITS-1:0];
        REG_LONG_PRESS: long_press_ms <= pwdata[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CENTER_X:   prdata = APB_DATA_BITS'(center_x);
      REG_CENTER_Y:   prdata = APB_DATA_BITS'(center_y);
      REG_DEADZONE:   prdata = APB_DATA_BITS'(deadzone);
      REG_LONG_PRESS: prdata = APB_DATA_BITS'(long_press_ms);
      default:        prdata = '0;
    endcase
  end

endmodule

### rtl/jnq_deflect.sv
module jnq_deflect
  import jnq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic [SAMPLE_BITS-1:0] sample_x,
  input  logic [SAMPLE_BITS-1:0] sample_y,
  input  logic [SAMPLE_BITS-1:0] center_x,
  input  logic [SAMPLE_BITS-1:0] center_y,
  input  logic [SAMPLE_BITS-1:0] deadzone,
  output jnq_deflect_t           deflect
);

  logic signed [SAMPLE_BITS:0] dx;
  logic signed [SAMPLE_BITS:0] dy;
  logic        [SAMPLE_BITS:0] mag_x;
  logic        [SAMPLE_BITS:0] mag_y;
  logic        [SAMPLE_BITS:0] dz;

  assign dx    = $signed({1'b0, sample_x}) - $signed({1'b0, center_x});
  assign dy    = $signed({1'b0, sample_y}) - $signed({1'b0, center_y});
  assign mag_x = dx[SAMPLE_BITS] ? $unsigned(-dx) : $unsigned(dx);
  assign mag_y = dy[SAMPLE_BITS] ? $unsigned(-dy) : $unsigned(dy);
  assign dz    = {1'b0, deadzone};

  always_comb begin
    deflect.off = (mag_x > dz) || (mag_y > dz);
    deflect.dir = EV_NONE;
    if (deflect.off) begin
      // x wins ties
      if (mag_x >= mag_y) begin
        deflect.dir = dx[SAMPLE_BITS] ? EV_LEFT : EV_RIGHT;
      end else begin
        deflect.dir = dy[SAMPLE_BITS] ? EV_UP : EV_DOWN;
      end
    end
  end

endmodule

### rtl/jnq_core.sv
`include "joystick_nav_event_qualifier_top_defines.svh"

module jnq_core
  import jnq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_x,
  input  logic [SAMPLE_BITS-1:0] in_y,
  input  logic                   in_pressed,
  input  logic [TIME_BITS-1:0]   in_now,
  output logic                   out_valid,
  input  logic                   out_ready,
  output jnq_event_t             out_code,
  input  logic [SAMPLE_BITS-1:0] center_x,
  input  logic [SAMPLE_BITS-1:0] center_y,
  input  logic [SAMPLE_BITS-1:0] deadzone,
  input  logic [HOLD_BITS-1:0]   long_press_ms
);

  // input stage
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_x;
  logic [SAMPLE_BITS-1:0] s1_y;
  logic                   s1_pressed;
  logic [TIME_BITS-1:0]   s1_now;

  // qualifier state
  logic                 direction_latched;
  logic                 switch_held;
  logic                 long_press_sent;
  logic                 chord_active;
  logic [TIME_BITS-1:0] press_start_ms;

  logic                 direction_latched_next;
  logic                 switch_held_next;
  logic                 long_press_sent_next;
  logic                 chord_active_next;
  logic [TIME_BITS-1:0] press_start_ms_next;
  jnq_event_t           code_next;

  jnq_deflect_t         deflect;
  logic                 advance;
  logic                 fire;
  logic                 emit_dir;
  logic                 fresh;
  logic                 lps_eff;
  logic                 chord_eff;
  logic [TIME_BITS-1:0] start_eff;
  logic [TIME_BITS-1:0] elapsed;

  assign advance  = !out_valid || out_ready;
  assign fire     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_x       <= in_x;
      s1_y       <= in_y;
      s1_pressed <= in_pressed;
      s1_now     <= in_now;
    end
  end

  jnq_deflect #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_deflect (
    .sample_x (s1_x),
    .sample_y (s1_y),
    .center_x (center_x),
    .center_y (center_y),
    .deadzone (deadzone),
    .deflect  (deflect)
  );

  assign emit_dir  = deflect.off && !direction_latched && !s1_pressed;
  assign fresh     = s1_pressed && !switch_held;
  assign lps_eff   = fresh ? 1'b0 : long_press_sent;
  assign chord_eff = fresh ? 1'b0 : chord_active;
  assign start_eff = fresh ? s1_now : press_start_ms;
  assign elapsed   = s1_now - start_eff;

  always_comb begin
    direction_latched_next = direction_latched;
    switch_held_next       = switch_held;
    long_press_sent_next   = long_press_sent;
    chord_active_next      = chord_active;
    press_start_ms_next    = press_start_ms;
    code_next              = EV_NONE;
    if (emit_dir) begin
      // direction wins the poll, nothing else moves
      direction_latched_next = 1'b1;
      code_next              = deflect.dir;
    end else begin
      if (!deflect.off) begin
        direction_latched_next = 1'b0;
      end
      if (s1_pressed) begin
        switch_held_next     = 1'b1;
        long_press_sent_next = lps_eff;
        chord_active_next    = chord_eff;
        press_start_ms_next  = start_eff;
        if (fresh && deflect.dir == EV_UP) begin
          chord_active_next = 1'b1;
          code_next         = EV_SHOT;
        end else if (!lps_eff && !chord_eff &&
                     elapsed >= TIME_BITS'(long_press_ms)) begin
          long_press_sent_next = 1'b1;
          code_next            = EV_BACK;
        end
      end else if (switch_held) begin
        switch_held_next  = 1'b0;
        chord_active_next = 1'b0;
        if (!long_press_sent && !chord_active) begin
          code_next = EV_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction_latched <= 1'b0;
      switch_held       <= 1'b0;
      long_press_sent   <= 1'b0;
      chord_active      <= 1'b0;
      press_start_ms    <= '0;
    end else if (fire) begin
      direction_latched <= direction_latched_next;
      switch_held       <= switch_held_next;
      long_press_sent   <= long_press_sent_next;
      chord_active      <= chord_active_next;
      press_start_ms    <= press_start_ms_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_code <= code_next;
    end
  end

  `JNQ_ASSERT_NOW(a_chord_needs_hold, clk, rst, chord_active, switch_held, "chord without hold")
  `JNQ_ASSERT_NOW(a_chord_not_back, clk, rst, chord_active, !long_press_sent, "chord and back")
  `JNQ_ASSERT_NEXT(a_back_flag, clk, rst, fire && code_next == EV_BACK, long_press_sent, "back")
  `JNQ_ASSERT_NEXT(a_dir_latches, clk, rst, fire && emit_dir, direction_latched, "direction latch")
  `JNQ_ASSERT_NOW(a_ready_when_empty, clk, rst, !out_valid, in_ready, "input blocked")

endmodule

### rtl/joystick_nav_event_qualifier_top.sv
// channel     role  payload
// sample_in   sink  sample_x, sample_y, switch_pressed, now_ms
// event_out   src   event_code
// apb         cfg   center_x, center_y, deadzone, long_press_ms
//
// one transaction in, one out, one every cycle unless event_out stalls
// two registers in the path, input register then result register
// a stalled result holds the input register; a third transaction waits
// rst is synchronous and clears the qualifier flags and valid bits
module joystick_nav_event_qualifier_top
  import jnq_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  jnq_in_if.sink                   sample_in,
  jnq_out_if.source                event_out,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_BITS-1:0]    paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [SAMPLE_BITS-1:0] center_x;
  logic [SAMPLE_BITS-1:0] center_y;
  logic [SAMPLE_BITS-1:0] deadzone;
  logic [HOLD_BITS-1:0]   long_press_ms;
  jnq_event_t             code;

  jnq_cfg_regs #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cfg_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .center_x      (center_x),
    .center_y      (center_y),
    .deadzone      (deadzone),
    .long_press_ms (long_press_ms)
  );

  jnq_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (sample_in.valid),
    .in_ready      (sample_in.ready),
    .in_x          (sample_in.sample_x),
    .in_y          (sample_in.sample_y),
    .in_pressed    (sample_in.switch_pressed),
    .in_now        (sample_in.now_ms),
    .out_valid     (event_out.valid),
    .out_ready     (event_out.ready),
    .out_code      (code),
    .center_x      (center_x),
    .center_y      (center_y),
    .deadzone      (deadzone),
    .long_press_ms (long_press_ms)
  );

  assign event_out.event_code = code;

endmodule

### sim/tb_joystick_nav_event_qualifier_top.sv
module tb_joystick_nav_event_qualifier_top
  import jnq_pkg::*;
();

  localparam int SAMPLE_W = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;

  typedef struct {
    logic [SAMPLE_W-1:0]  x;
    logic [SAMPLE_W-1:0]  y;
    logic                 sw;
    logic [TIME_BITS-1:0] now;
    bit                   has_fixed;
    jnq_event_t           fixed_ev;
  } poll_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  jnq_in_if #(.SAMPLE_BITS(SAMPLE_W)) sample_if ();
  jnq_out_if event_if ();

  joystick_nav_event_qualifier_top #(.SAMPLE_BITS(SAMPLE_W)) uut (
    .clk       (clk),
    .rst       (rst),
    .sample_in (sample_if),
    .event_out (event_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // qualifier model state and register copies
  logic [SAMPLE_W-1:0]  cfg_cx = SAMPLE_W'(CENTER_X_RESET);
  logic [SAMPLE_W-1:0]  cfg_cy = SAMPLE_W'(CENTER_Y_RESET);
  logic [SAMPLE_W-1:0]  cfg_dz = SAMPLE_W'(DEADZONE_RESET);
  logic [HOLD_BITS-1:0] cfg_lp = HOLD_BITS'(LONG_PRESS_RESET);
  bit dir_latched = 1'b0;
  bit sw_held = 1'b0;
  bit back_sent = 1'b0;
  bit chord_on = 1'b0;
  logic [TIME_BITS-1:0] press_ms = '0;

  poll_t pending_polls[$];
  jnq_event_t expected_events[$];
  poll_t cur_poll;
  jnq_event_t predicted_event;
  logic [TIME_BITS-1:0] poll_ms = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int polls_queued = 0;
  int polls_accepted = 0;
  int phase_polls = 0;
  int settings_count = 0;
  int event_tally [8] = '{default: 0};

  poll_t directed_polls [25] = '{
    '{12'd1955, 12'd1880, 1'b0, 32'd0,          1'b1, EV_NONE},
    '{12'd4095, 12'd1880, 1'b0, 32'd1,          1'b1, EV_RIGHT},
    '{12'd4095, 12'd1880, 1'b0, 32'd2,          1'b1, EV_NONE},
    '{12'd1955, 12'd1880, 1'b0, 32'd3,          1'b1, EV_NONE},
    '{12'd0,    12'd1880, 1'b0, 32'd4,          1'b1, EV_LEFT},
    '{12'd1955, 12'd1880, 1'b0, 32'd5,          1'b1, EV_NONE},
    '{12'd1955, 12'd0,    1'b0, 32'd6,          1'b1, EV_UP},
    '{12'd1955, 12'd1880, 1'b0, 32'd7,          1'b1, EV_NONE},
    '{12'd1955, 12'd4095, 1'b0, 32'd8,          1'b1, EV_DOWN},
    '{12'd1955, 12'd1880, 1'b0, 32'd9,          1'b1, EV_NONE},
    '{12'd2455, 12'd2380, 1'b0, 32'd10,         1'b1, EV_RIGHT},
    '{12'd2355, 12'd1880, 1'b0, 32'd11,         1'b1, EV_NONE},
    '{12'd2356, 12'd1880, 1'b0, 32'd12,         1'b1, EV_RIGHT},
    '{12'd1955, 12'd1880, 1'b1, 32'd1000,       1'b1, EV_NONE},
    '{12'd1955, 12'd1880, 1'b1, 32'd1599,       1'b1, EV_NONE},
    '{12'd1955, 12'd1880, 1'b1, 32'd1600,       1'b1, EV_BACK},
    '{12'd1955, 12'd1880, 1'b0, 32'd1800,       1'b1, EV_NONE},
    '{12'd1955, 12'd1880, 1'b1, 32'd2000,       1'b1, EV_NONE},
    '{12'd1955, 12'd1880, 1'b0, 32'd2100,       1'b1, EV_OK},
    '{12'd1955, 12'd0,    1'b1, 32'd2200,       1'b1, EV_SHOT},
    '{12'd1955, 12'd0,    1'b0, 32'd2300,       1'b0, EV_NONE},
    '{12'd1955, 12'd1880, 1'b0, 32'd2400,       1'b0, EV_NONE},
    '{12'd1955, 12'd1880, 1'b1, 32'hFFFF_FF00,  1'b1, EV_NONE},
    '{12'd1955, 12'd1880, 1'b1, 32'h0000_0200,  1'b1, EV_BACK},
    '{12'd1955, 12'd1880, 1'b0, 32'h0000_0300,  1'b1, EV_NONE}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic jnq_event_t qualify_poll(poll_t p);
    int dx;
    int dy;
    int dz;
    bit off;
    jnq_event_t dir;
    logic [TIME_BITS-1:0] held_ms;
    dx = int'(p.x) - int'(cfg_cx);
    dy = int'(p.y) - int'(cfg_cy);
    dz = int'(cfg_dz);
    off = dx > dz || dx < -dz || dy > dz || dy < -dz;
    dir = EV_NONE;
    if (off) begin
      if ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy)) dir = dx > 0 ? EV_RIGHT : EV_LEFT;
      else dir = dy > 0 ? EV_DOWN : EV_UP;
    end
    if (off && !dir_latched && !p.sw) begin
      dir_latched = 1'b1;
      return dir;
    end
    if (!off) dir_latched = 1'b0;
    if (p.sw && !sw_held) begin
      sw_held = 1'b1;
      back_sent = 1'b0;
      chord_on = 1'b0;
      press_ms = p.now;
      if (dir == EV_UP) begin
        chord_on = 1'b1;
        return EV_SHOT;
      end
    end
    held_ms = p.now - press_ms;
    if (p.sw && sw_held && !back_sent && !chord_on && held_ms >= cfg_lp) begin
      back_sent = 1'b1;
      return EV_BACK;
    end
    if (!p.sw && sw_held) begin
      sw_held = 1'b0;
      if (!back_sent && !chord_on) return EV_OK;
      chord_on = 1'b0;
    end
    return EV_NONE;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 30) $display("mismatch at %0t: %s", $time, msg);
  endtask

  // sample channel: one transaction offered per free slot
  always @(posedge clk) begin
    if (rst) begin
      sample_if.valid <= 1'b0;
    end else begin
      if (sample_if.valid && sample_if.ready) begin
        predicted_event = qualify_poll(cur_poll);
        expected_events.push_back(cur_poll.has_fixed ? cur_poll.fixed_ev : predicted_event);
        polls_accepted++;
      end
      if (!sample_if.valid || sample_if.ready) begin
        if (pending_polls.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cur_poll = pending_polls.pop_front();
          sample_if.sample_x <= cur_poll.x;
          sample_if.sample_y <= cur_poll.y;
          sample_if.switch_pressed <= cur_poll.sw;
          sample_if.now_ms <= cur_poll.now;
          sample_if.valid <= 1'b1;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // event channel
  always @(posedge clk) begin
    if (rst) begin
      event_if.ready <= 1'b0;
    end else begin
      if (event_if.valid && event_if.ready) begin
        event_tally[event_if.event_code]++;
        if (expected_events.size() == 0) begin
          note_mismatch($sformatf("event %0d with nothing outstanding", event_if.event_code));
        end else if (event_if.event_code !== expected_events[0]) begin
          note_mismatch($sformatf("event %0d, wanted %s", event_if.event_code,
                                  expected_events[0].name()));
          void'(expected_events.pop_front());
        end else begin
          void'(expected_events.pop_front());
        end
      end
      event_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(jnq_reg_idx_t idx, logic [APB_DATA_BITS-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CENTER_X: cfg_cx = value[SAMPLE_W-1:0];
      REG_CENTER_Y: cfg_cy = value[SAMPLE_W-1:0];
      REG_DEADZONE: cfg_dz = value[SAMPLE_W-1:0];
      REG_LONG_PRESS: cfg_lp = value[HOLD_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(int cx, int cy, int dz, int lp);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_DEADZONE, dz);
    write_reg(REG_LONG_PRESS, lp);
    settings_count++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (polls_accepted != polls_queued || expected_events.size() != 0);
  endtask

  function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
    return v[SAMPLE_W-1:0];
  endfunction

  // random offset, often right on the edge of the span
  function automatic int spread(int span);
    case ($urandom_range(0, 5))
      0: return span;
      1: return -span;
      default: return int'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic logic [TIME_BITS-1:0] tick_ms();
    poll_ms += $urandom_range(0, 30);
    return poll_ms;
  endfunction

  task automatic queue_poll(logic [SAMPLE_W-1:0] x, logic [SAMPLE_W-1:0] y, logic sw,
                            logic [TIME_BITS-1:0] at);
    poll_t p;
    p = '{x, y, sw, at, 1'b0, EV_NONE};
    pending_polls.push_back(p);
    polls_queued++;
    phase_polls++;
  endtask

  task automatic queue_stick(jnq_event_t dir, logic sw, logic [TIME_BITS-1:0] at);
    int m;
    int ox;
    int oy;
    if ($urandom_range(0, 3) == 0) m = int'(cfg_dz) + int'($urandom_range(0, 1));
    else m = int'(cfg_dz) + 1 + int'($urandom_range(0, 1500));
    case (dir)
      EV_UP: begin
        oy = -m;
        ox = spread(m);
      end
      EV_DOWN: begin
        oy = m;
        ox = spread(m);
      end
      EV_LEFT: begin
        ox = -m;
        oy = spread(m);
      end
      EV_RIGHT: begin
        ox = m;
        oy = spread(m);
      end
      default: begin
        ox = spread(int'(cfg_dz));
        oy = spread(int'(cfg_dz));
      end
    endcase
    queue_poll(clamp_sample(int'(cfg_cx) + ox), clamp_sample(int'(cfg_cy) + oy), sw, at);
  endtask

  task automatic queue_gesture();
    jnq_event_t dir;
    logic [TIME_BITS-1:0] t0;
    int n;
    dir = jnq_event_t'($urandom_range(EV_UP, EV_RIGHT));
    n = $urandom_range(1, 3);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        repeat (n) queue_stick(dir, 1'b0, tick_ms());
        repeat ($urandom_range(1, 2)) queue_stick(EV_NONE, 1'b0, tick_ms());
      end
      3, 4: begin
        repeat (n) queue_stick(EV_NONE, 1'b1, tick_ms());
        queue_stick(EV_NONE, 1'b0, tick_ms());
      end
      5, 6: begin
        // hold across the long-press threshold
        t0 = tick_ms();
        queue_stick(EV_NONE, 1'b1, t0);
        queue_stick(($urandom_range(0, 2) == 0) ? dir : EV_NONE, 1'b1, t0 + cfg_lp - 1);
        queue_stick(EV_NONE, 1'b1, t0 + cfg_lp);
        queue_stick(EV_NONE, 1'b1, t0 + cfg_lp + $urandom_range(0, 100));
        poll_ms = t0 + cfg_lp + 200;
        queue_stick(EV_NONE, 1'b0, tick_ms());
      end
      7: begin
        // press with the stick deflected, chord or not
        queue_stick(($urandom_range(0, 1) == 0) ? EV_UP : dir, 1'b1, tick_ms());
        repeat (n) queue_stick(dir, 1'b1, tick_ms());
        queue_stick(($urandom_range(0, 1) == 0) ? dir : EV_NONE, 1'b0, tick_ms());
        queue_stick(EV_NONE, 1'b0, tick_ms());
      end
      default: begin
        repeat (n) queue_poll(12'($urandom()), 12'($urandom()), 1'($urandom_range(0, 1)),
                              ($urandom_range(0, 1) == 0) ? $urandom() : tick_ms());
      end
    endcase
  endtask

  task automatic run_phase(int idle, int stall, int polls);
    idle_pct = idle;
    stall_pct = stall;
    phase_polls = 0;
    while (phase_polls < polls) queue_gesture();
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sample_if.valid = 1'b0;
    sample_if.sample_x = '0;
    sample_if.sample_y = '0;
    sample_if.switch_pressed = 1'b0;
    sample_if.now_ms = '0;
    event_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_polls[i]) begin
      pending_polls.push_back(directed_polls[i]);
      polls_queued++;
    end
    wait_drained();

    poll_ms = 32'd5000;
    run_phase(0, 0, 100);

    program_regs(0, 0, 0, 0);
    run_phase(81, 0, 100);

    program_regs(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 65535);
    run_phase(0, 81, 80);

    // sender held back mid-setting until every event is in
    program_regs($urandom_range(1500, 2500), $urandom_range(1500, 2500),
                 $urandom_range(50, 800), $urandom_range(0, 300));
    run_phase(28, 28, 60);
    run_phase(28, 28, 60);

    program_regs(SAMPLE_MAX, 0, 1, 1);
    run_phase(81, 81, 80);

    poll_ms = 32'hFFFF_F000;
    program_regs(0, SAMPLE_MAX, 2000, 65535);
    run_phase(0, 0, 60);

    program_regs($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
                 $urandom_range(0, SAMPLE_MAX), $urandom_range(0, 65535));
    run_phase(28, 28, 100);

    program_regs(CENTER_X_RESET, CENTER_Y_RESET, DEADZONE_RESET, LONG_PRESS_RESET);
    run_phase(0, 0, 60);

    repeat (10) @(posedge clk);
    if (expected_events.size() != 0)
      note_mismatch($sformatf("%0d events never arrived", expected_events.size()));

    $display("%0d polls over %0d register settings, with idle and stall mixes up to 81 in 100",
             polls_accepted, settings_count);
    $display("events: none %0d up %0d down %0d left %0d right %0d ok %0d back %0d shot %0d",
             event_tally[EV_NONE], event_tally[EV_UP], event_tally[EV_DOWN],
             event_tally[EV_LEFT], event_tally[EV_RIGHT], event_tally[EV_OK],
             event_tally[EV_BACK], event_tally[EV_SHOT]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
